// ----- rtl/xss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package xss_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned HALF_W      = WORD_W / 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [WORD_W-1:0] XS_MULT = 64'h2545_f491_4f6c_dd1d;

  localparam int unsigned XS_SHIFT_A  = 12;
  localparam int unsigned XS_SHIFT_B  = 25;
  localparam int unsigned XS_SHIFT_C  = 27;
  localparam int unsigned FRAC24_SHR  = 40;
  localparam int unsigned FRAC53_SHR  = 11;

  typedef enum logic [1:0] {
    OP_RAW     = 2'd0,
    OP_FRAC24  = 2'd1,
    OP_FRAC53  = 2'd2,
    OP_BOUNDED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    JOB_RAW,
    JOB_FRAC24,
    JOB_FRAC53,
    JOB_BOUNDED,
    JOB_FULL_SPAN
  } job_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SHIFT,
    BK_MUL,
    BK_DIV,
    BK_FIN
  } bk_state_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [WORD_W-1:0] range_low;
    logic signed [WORD_W-1:0] range_high;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]        word;
    logic signed [WORD_W-1:0] bounded_value;
  } out_item_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] span;
  } cmd_t;

  function automatic logic [WORD_W-1:0] xs_advance(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] t;
    t = s ^ (s >> XS_SHIFT_A);
    t = t ^ (t << XS_SHIFT_B);
    t = t ^ (t >> XS_SHIFT_C);
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/xss_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module xss_front import xss_pkg::*; (
  input  wire in_item_t push_data,
  input  wire logic     push,
  input  wire logic     q_full,
  output cmd_t          q_wr_data,
  output logic          q_wr
);

  logic [WORD_W-1:0] span;

  assign span = WORD_W'(push_data.range_high) - WORD_W'(push_data.range_low) + WORD_W'(1);

  always_comb begin
    q_wr_data.lo   = WORD_W'(push_data.range_low);
    q_wr_data.span = span;
    case (push_data.operation)
      OP_RAW:    q_wr_data.kind = JOB_RAW;
      OP_FRAC24: q_wr_data.kind = JOB_FRAC24;
      OP_FRAC53: q_wr_data.kind = JOB_FRAC53;
      OP_BOUNDED: begin
        // span wrapped to zero: whole 64-bit range, no draw
        q_wr_data.kind = (span == '0) ? JOB_FULL_SPAN : JOB_BOUNDED;
      end
      default:   q_wr_data.kind = JOB_RAW;
    endcase
  end

  assign q_wr = push & ~q_full;

endmodule
`default_nettype wire

// ----- rtl/xss_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module xss_queue import xss_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd,
  output logic      rd_valid,
  output cmd_t      rd_data
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign do_wr    = wr & ~full;
  assign do_rd    = rd & rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/xss_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module xss_back import xss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [WORD_W-1:0] cfg_seed,
  input  wire logic              q_valid,
  input  wire cmd_t              q_data,
  output logic                   q_rd,
  output logic                   out_valid,
  output out_item_t              out_item,
  input  wire logic              out_take
);

  localparam int unsigned CNT_W = $clog2(WORD_W);

  bk_state_t              fsm_r, fsm_nxt;
  logic [WORD_W-1:0]      gen_r;
  cmd_t                   job_r;
  logic [WORD_W-1:0]      acc_r;
  logic [WORD_W-1:0]      prod_r;
  logic [1:0]             step_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [WORD_W-1:0]      rem_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic                   cfg_take;
  logic                   start;
  logic                   load_out;
  logic                   slot_free;
  logic [HALF_W-1:0]      mul_a, mul_b;
  logic [WORD_W:0]        div_sh;
  logic [WORD_W:0]        div_diff;
  out_item_t              result;

  assign slot_free = ~out_valid_r | out_take;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // next state
  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      BK_IDLE: begin
        if (q_valid) begin
          fsm_nxt = (q_data.kind == JOB_FULL_SPAN) ? BK_FIN : BK_SHIFT;
        end
      end
      BK_SHIFT: fsm_nxt = BK_MUL;
      BK_MUL: begin
        if (step_r == 2'd3) begin
          fsm_nxt = (job_r.kind == JOB_BOUNDED) ? BK_DIV : BK_FIN;
        end
      end
      BK_DIV: begin
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          fsm_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        if (slot_free) begin
          fsm_nxt = BK_IDLE;
        end
      end
      default: fsm_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cfg_ready = 1'b0;
    start     = 1'b0;
    load_out  = 1'b0;
    case (fsm_r)
      BK_IDLE: begin
        cfg_ready = 1'b1;
        start     = q_valid;
      end
      BK_FIN:  load_out = slot_free;
      default: begin
        cfg_ready = 1'b0;
      end
    endcase
  end

  assign q_rd     = start;
  assign cfg_take = cfg_valid & cfg_ready;

  // shared 32x32 multiplier: low*low, high*low, low*high
  always_comb begin
    case (step_r)
      2'd0: begin
        mul_a = gen_r[HALF_W-1:0];
        mul_b = XS_MULT[HALF_W-1:0];
      end
      2'd1: begin
        mul_a = gen_r[WORD_W-1:HALF_W];
        mul_b = XS_MULT[HALF_W-1:0];
      end
      default: begin
        mul_a = gen_r[HALF_W-1:0];
        mul_b = XS_MULT[WORD_W-1:HALF_W];
      end
    endcase
  end

  assign div_sh   = {rem_r, acc_r[WORD_W-1]};
  assign div_diff = div_sh - {1'b0, job_r.span};

  always_comb begin
    result.word          = '0;
    result.bounded_value = '0;
    case (job_r.kind)
      JOB_RAW:       result.word = acc_r;
      JOB_FRAC24:    result.word = acc_r >> FRAC24_SHR;
      JOB_FRAC53:    result.word = acc_r >> FRAC53_SHR;
      JOB_BOUNDED:   result.bounded_value = job_r.lo + rem_r;
      JOB_FULL_SPAN: result.bounded_value = job_r.lo;
      default:       result.word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= BK_IDLE;
      gen_r       <= WORD_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      fsm_r <= fsm_nxt;
      if (cfg_take) begin
        gen_r <= (cfg_seed != '0) ? cfg_seed : WORD_W'(1);
      end else if (fsm_r == BK_SHIFT) begin
        gen_r <= xs_advance(gen_r);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      job_r <= q_data;
    end
    if (load_out) begin
      out_r <= result;
    end
    case (fsm_r)
      BK_SHIFT: begin
        step_r <= 2'd0;
      end
      BK_MUL: begin
        prod_r <= WORD_W'(mul_a) * WORD_W'(mul_b);
        step_r <= step_r + 2'd1;
        // only the low half of each cross product reaches the word
        if (step_r == 2'd1) begin
          acc_r <= prod_r;
        end else if (step_r != 2'd0) begin
          acc_r <= acc_r + {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
        end
        cnt_r <= '0;
        rem_r <= '0;
      end
      BK_DIV: begin
        // restoring step: one dividend bit per cycle
        cnt_r <= cnt_r + CNT_W'(1);
        acc_r <= acc_r << 1;
        if (!div_diff[WORD_W]) begin
          rem_r <= div_diff[WORD_W-1:0];
        end else begin
          rem_r <= div_sh[WORD_W-1:0];
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

`ifndef SYNTH
  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r != '0)
    else $error("generator state reached zero");

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == BK_DIV) |-> (rem_r < job_r.span))
    else $error("remainder not below span");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_take) |=> ($stable(out_r) && out_valid_r))
    else $error("waiting result overwritten or lost");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> (fsm_r == BK_IDLE && q_valid))
    else $error("queue read outside idle");

  a_full_span_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (start && q_data.kind == JOB_FULL_SPAN && !cfg_take) |=> $stable(gen_r))
    else $error("full span request advanced state");
`endif

endmodule
`default_nettype wire

// ----- rtl/xorshift_star_random_generator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake           | Payload
// ---------+---------------------+----------------------------------------
// input    | push / full         | in_data  (operation, range_low, range_high)
// result   | pop / empty         | out_data (word, bounded_value)
// config   | cfg_valid/cfg_ready | cfg_seed (reloads state, zero becomes one)
//
// Raw and fraction requests pass through the back end as pop, state advance, four
// steps of the shared 32x32 multiplier, result load. Bounded requests add the
// one-bit-per-cycle restoring remainder unit; full-range goes from pop to load.
// A two-entry request queue sits between front and back, so requests keep arriving
// while a result waits on the output register; full rises only when the queue fills.
// Synchronous active-low reset returns the state to one; no clearing pass.
module xorshift_star_random_generator_core import xss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire in_item_t          in_data,
  output logic                   empty,
  input  wire logic              pop,
  output out_item_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [WORD_W-1:0] cfg_seed
);

  cmd_t q_wr_data;
  logic q_wr;
  logic q_full;
  logic q_rd;
  logic q_valid;
  cmd_t q_rd_data;
  logic out_valid;

  assign full  = q_full;
  assign empty = ~out_valid;

  xss_front u_front (
    .push_data (in_data),
    .push      (push),
    .q_full    (q_full),
    .q_wr_data (q_wr_data),
    .q_wr      (q_wr)
  );

  xss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  xss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_seed  (cfg_seed),
    .q_valid   (q_valid),
    .q_data    (q_rd_data),
    .q_rd      (q_rd),
    .out_valid (out_valid),
    .out_item  (out_data),
    .out_take  (pop)
  );

endmodule
`default_nettype wire

// ----- tb/sv/xss_draw_checker.sv -----
`timescale 1ns / 1ps
module xss_draw_checker import xss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              full,
  input  in_item_t          in_data,
  input  logic              empty,
  input  logic              pop,
  input  out_item_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [WORD_W-1:0] cfg_seed,
  output int                errors,
  output int                pending,
  output int                checked
);

  localparam logic [63:0] MIX_MULT = 64'h2545_f491_4f6c_dd1d;

  logic [63:0] gen_state;
  out_item_t   expected_draws[$];

  task automatic predict_draw(input in_item_t req);
    logic [63:0] s;
    logic [63:0] prod;
    logic [63:0] span;
    out_item_t   res;
    res  = '0;
    span = req.range_high - req.range_low + 64'd1;
    if (req.operation == OP_BOUNDED && span == '0) begin
      // full 64-bit span: hand back the low bound and hold the state
      res.bounded_value = req.range_low;
    end else begin
      s = gen_state;
      s = s ^ (s >> 12);
      s = s ^ (s << 25);
      s = s ^ (s >> 27);
      gen_state = s;
      prod = s * MIX_MULT;
      case (op_t'(req.operation))
        OP_RAW:    res.word = prod;
        OP_FRAC24: res.word = prod >> 40;
        OP_FRAC53: res.word = prod >> 11;
        default:   res.bounded_value = req.range_low + (prod % span);
      endcase
    end
    expected_draws.push_back(res);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      gen_state = 64'd1;
      expected_draws.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gen_state = (cfg_seed == '0) ? 64'd1 : cfg_seed;
      end
      // compare before predicting so a result can never match its own request
      if (pop && !empty) begin
        if (expected_draws.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: word %h bounded %h",
                   $time, out_data.word, out_data.bounded_value);
        end else begin
          want = expected_draws.pop_front();
          checked++;
          if (out_data.word !== want.word) begin
            errors++;
            $display("%0t: word mismatch: expected %h, got %h",
                     $time, want.word, out_data.word);
          end
          if (out_data.bounded_value !== want.bounded_value) begin
            errors++;
            $display("%0t: bounded_value mismatch: expected %h, got %h",
                     $time, want.bounded_value, out_data.bounded_value);
          end
        end
      end
      if (push && !full) begin
        predict_draw(in_data);
      end
    end
    pending = expected_draws.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import xss_pkg::*;

  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;

  logic              clk;
  logic              rst_n;
  logic              push;
  logic              full;
  in_item_t          in_data;
  logic              empty;
  logic              pop;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [WORD_W-1:0] cfg_seed;

  int errors;
  int pending;
  int checked;
  bit calm;
  int n_requests;
  int n_bounded;
  int n_seeds;

  xorshift_star_random_generator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_seed  (cfg_seed)
  );

  xss_draw_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_seed  (cfg_seed),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("DONE: errors detected");
    $finish;
  end

  // result side: stall in short bursts unless the run has gone calm
  initial begin : drain_side
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      pop <= rst_n && (stall_left == 0);
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t mk(input op_t op, input logic [63:0] lo,
                                  input logic [63:0] hi);
    in_item_t r;
    r.operation  = op;
    r.range_low  = lo;
    r.range_high = hi;
    return r;
  endfunction

  function automatic logic [63:0] edge_value();
    case ($urandom_range(0, 4))
      0:       return S64_MIN;
      1:       return S64_MAX;
      2:       return 64'd0;
      3:       return '1;
      default: return 64'd1;
    endcase
  endfunction

  function automatic in_item_t rand_request();
    in_item_t    r;
    logic [63:0] a;
    a = rnd64();
    r = mk(op_t'($urandom_range(0, 3)), a, rnd64());
    if (r.operation == OP_BOUNDED) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: r.range_high = a + 64'($urandom_range(0, 1000));
        4:          r.range_high = a + (64'd1 << $urandom_range(0, 63)) - 64'd1;
        5:          r.range_high = a - 64'd1;   // span wraps to zero
        6: begin
          r.range_low  = edge_value();
          r.range_high = edge_value();
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input in_item_t req);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (full);
    n_requests++;
    if (req.operation == OP_BOUNDED) n_bounded++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_seed(input logic [63:0] s);
    cfg_seed  <= s;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    n_seeds++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [63:0] seed_v;
    rst_n      = 1'b0;
    push       = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_seed   = '0;
    calm       = 1'b0;
    n_requests = 0;
    n_bounded  = 0;
    n_seeds    = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset state, every operation and the awkward bounds
    send_request(mk(OP_RAW, rnd64(), rnd64()));
    send_request(mk(OP_FRAC24, '0, '0));
    send_request(mk(OP_FRAC53, '1, '1));
    send_request(mk(OP_BOUNDED, 64'd0, 64'd0));
    send_request(mk(OP_BOUNDED, S64_MIN, S64_MAX));
    send_request(mk(OP_RAW, S64_MAX, S64_MIN));
    send_request(mk(OP_BOUNDED, 64'd0, '1));
    send_request(mk(OP_BOUNDED, 64'd5, -64'sd5));
    send_request(mk(OP_BOUNDED, S64_MAX, S64_MIN));
    send_request(mk(OP_BOUNDED, S64_MIN, S64_MIN));
    send_request(mk(OP_BOUNDED, S64_MAX, S64_MAX));
    send_request(mk(OP_BOUNDED, -64'sd100, 64'sd100));
    send_request(mk(OP_BOUNDED, 64'd0, S64_MAX));
    send_request(mk(OP_BOUNDED, S64_MIN, '1));

    // zero seed must come up as one
    drain_results();
    load_seed('0);
    send_request(mk(OP_RAW, '0, '0));
    send_request(mk(OP_FRAC24, rnd64(), rnd64()));
    send_request(mk(OP_FRAC53, rnd64(), rnd64()));
    send_request(mk(OP_BOUNDED, rnd64(), rnd64()));

    drain_results();
    load_seed('1);
    send_request(mk(OP_RAW, '1, '0));
    send_request(mk(OP_BOUNDED, 64'd1, 64'd6));
    send_request(mk(OP_FRAC53, '0, '1));

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       seed_v = S64_MIN;
        1:       seed_v = 64'd1;
        default: seed_v = rnd64();
      endcase
      drain_results();
      calm = (p == 5);
      load_seed(seed_v);
      repeat (240) send_request(rand_request());
    end

    drain_results();
    repeat (100) @(negedge clk);
    $display("sent %0d requests (%0d bounded) over %0d seed loads", n_requests,
             n_bounded, n_seeds);
    $display("checked %0d results, %0d left outstanding", checked, pending);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- xorshift_star_random_generator_core.f -----
rtl/xss_pkg.sv
rtl/xss_front.sv
rtl/xss_queue.sv
rtl/xss_back.sv
rtl/xorshift_star_random_generator_core.sv
tb/sv/xss_draw_checker.sv
tb/sv/tb.sv
